FILE: hw/rtl/rbs_pkg.sv
// Shared constants, codes and types of the recency burst stack.
package rbs_pkg;

   localparam int KEY_PORT_W        = 32;
   localparam int SCORE_W           = 8;
   localparam int SIZE_W            = 8;
   localparam int DEPTH_DEFAULT     = 255;
   localparam int KEY_WIDTH_DEFAULT = 32;
   localparam int GROUP_SIZE        = 16;
   localparam int SIZE_RESET        = 255;

   localparam logic [SCORE_W-1:0] FRESH_SCORE = 8'd255;

   typedef enum logic {
      CMD_TOUCH  = 1'b0,
      CMD_LOOKUP = 1'b1
   } rbs_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_FINISH
   } rbs_state_type;

   typedef struct packed {
      logic capture;
      logic update;
   } rbs_ctl_type;

endpackage

FILE: hw/rtl/rbs_if.sv
// Request and response channel interfaces of the recency burst stack.
interface rbs_req_if import rbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [KEY_PORT_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink (input valid, input cmd, input key, output ready);
endinterface

interface rbs_rsp_if import rbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SCORE_W-1:0]    score;
   logic                  evicted_valid;
   logic [KEY_PORT_W-1:0] evicted_key;

   modport source (output valid, output score, output evicted_valid, output evicted_key,
                   input ready);
   modport sink (input valid, input score, input evicted_valid, input evicted_key,
                 output ready);
endinterface

FILE: hw/rtl/rbs_cell.sv
// One stack cell: holds a key and its score, compares, ages and shifts.
module rbs_cell import rbs_pkg::*; #(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT,
   parameter int CNT_W     = 8,
   parameter int INDEX     = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rbs_ctl_type          ctl,
   input  logic [CNT_W-1:0]     count,
   input  logic [KEY_WIDTH-1:0] probe_key,
   input  logic                 shift,
   input  logic [KEY_WIDTH-1:0] left_key,
   input  logic [SCORE_W-1:0]   left_aged,
   output logic [KEY_WIDTH-1:0] cell_key,
   output logic [SCORE_W-1:0]   cell_score,
   output logic [SCORE_W-1:0]   cell_aged,
   output logic                 hit,
   output logic                 tail
);

   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [SCORE_W-1:0]   score_ff, score_in;
   logic                 hit_ff, hit_in;
   logic                 valid;

   assign valid     = count > CNT_W'(INDEX);
   assign tail      = count == CNT_W'(INDEX + 1);
   assign cell_aged = (score_ff == '0) ? '0 : score_ff - 1'b1;

   always_comb begin
      hit_in   = hit_ff;
      key_in   = key_ff;
      score_in = score_ff;
      if (ctl.capture) begin
         hit_in = valid && (key_ff == probe_key);
      end
      if (ctl.update) begin
         if (shift) begin
            key_in   = left_key;
            score_in = left_aged;
         end else begin
            score_in = cell_aged;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      score_ff <= score_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign cell_key   = key_ff;
   assign cell_score = score_ff;
   assign hit        = hit_ff;

endmodule

FILE: hw/rtl/rbs_group.sv
// Registered reduction of one group of cells: hit flag, hit score, tail key.
module rbs_group import rbs_pkg::*; #(
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT,
   parameter int SIZE      = GROUP_SIZE
) (
   input  logic                            clock,
   input  logic [SIZE-1:0]                 hit,
   input  logic [SIZE-1:0]                 tail,
   input  logic [SIZE-1:0][SCORE_W-1:0]    score,
   input  logic [SIZE-1:0][KEY_WIDTH-1:0]  key,
   output logic                            grp_hit_ff,
   output logic [SCORE_W-1:0]              grp_score_ff,
   output logic [KEY_WIDTH-1:0]            grp_key_ff
);

   logic                 grp_hit_in;
   logic [SCORE_W-1:0]   grp_score_in;
   logic [KEY_WIDTH-1:0] grp_key_in;

   always_comb begin
      grp_hit_in   = |hit;
      grp_score_in = '0;
      grp_key_in   = '0;
      for (int i = 0; i < SIZE; i++) begin
         grp_score_in = grp_score_in | (hit[i] ? score[i] : '0);
         grp_key_in   = grp_key_in | (tail[i] ? key[i] : '0);
      end
   end

   always_ff @(posedge clock) begin
      grp_hit_ff   <= grp_hit_in;
      grp_score_ff <= grp_score_in;
      grp_key_ff   <= grp_key_in;
   end

endmodule

FILE: hw/rtl/recency_burst_stack_unit.sv
// Top level of the recency burst stack: control, count, cell chain and response register.
//
// Usage:
//   req carries a request: cmd (touch or lookup) and key. rsp returns one
//   response per request: the key's score before the request (0 if absent)
//   and, for a touch into a full stack, the evicted oldest key.
//   csr_wr_en/csr_wr_data set the stack size (0 reads as 1, clamped to
//   MAX_DEPTH); shrinking drops the oldest keys. Write it only when idle.
// Timing:
//   A request is compared in every cell as it is accepted, then reduced
//   per group of cells; at the update step the response register loads
//   and, for a touch, the cell chain shifts. No new request is accepted
//   until the compare / group reduce / update sequence has finished.
// Reset:
//   Synchronous, active high: stack empty, size SIZE_RESET capped at MAX_DEPTH, no response.
// Backpressure:
//   A new request is accepted while a response still waits; if the
//   response register is still full at the update step, that step holds
//   until rsp.ready.
module recency_burst_stack_unit import rbs_pkg::*; #(
   parameter int MAX_DEPTH = DEPTH_DEFAULT,
   parameter int KEY_WIDTH = KEY_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   rbs_req_if.sink           req,
   rbs_rsp_if.source         rsp
);

   localparam int CNT_W      = $clog2(MAX_DEPTH + 1);
   localparam int NUM_GROUPS = (MAX_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD        = NUM_GROUPS * GROUP_SIZE;
   localparam logic [SIZE_W-1:0] SIZE_CAP   = SIZE_W'(MAX_DEPTH);
   localparam logic [SIZE_W-1:0] RESET_SIZE =
      (SIZE_RESET > MAX_DEPTH) ? SIZE_W'(MAX_DEPTH) : SIZE_W'(SIZE_RESET);

   rbs_state_type state_ff, state_in;
   rbs_ctl_type   ctl;
   logic          fin_go;

   rbs_cmd_type          cmd_ff, cmd_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [KEY_WIDTH-1:0] probe_key;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] stack_size_ff, stack_size_in;
   logic [SIZE_W-1:0] size_clamp;

   logic [PAD-1:0][KEY_WIDTH-1:0] cell_key;
   logic [PAD-1:0][SCORE_W-1:0]   cell_score;
   logic [PAD-1:0][SCORE_W-1:0]   cell_aged;
   logic [PAD-1:0]                hit_vec, tail_vec, is_d, drop, shift;

   logic [NUM_GROUPS-1:0]                grp_hit;
   logic [NUM_GROUPS-1:0][SCORE_W-1:0]   grp_score;
   logic [NUM_GROUPS-1:0][KEY_WIDTH-1:0] grp_key;
   logic [NUM_GROUPS-1:0]                group_drop, later_drop;

   logic                 hit_any, full, evict;
   logic [SCORE_W-1:0]   score_or;
   logic [KEY_WIDTH-1:0] tail_key_or;
   logic [CNT_W-1:0]     d_pos;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SCORE_W-1:0]    rsp_score_ff, rsp_score_in;
   logic                  rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [KEY_PORT_W-1:0] rsp_ev_key_ff, rsp_ev_key_in;

   // control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_GROUP;
            end
         end
         ST_GROUP: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req.ready   = state_ff == ST_IDLE;
      ctl.capture = (state_ff == ST_IDLE) && req.valid;
      fin_go      = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);
      ctl.update  = fin_go && (cmd_ff == CMD_TOUCH);
   end

   assign probe_key = KEY_WIDTH'(req.key);
   assign cmd_in    = ctl.capture ? rbs_cmd_type'(req.cmd) : cmd_ff;
   assign key_in    = ctl.capture ? probe_key : key_ff;

   // cell chain
   for (genvar i = 0; i < PAD; i++) begin : g_cell
      if (i < MAX_DEPTH) begin : g_real
         logic [KEY_WIDTH-1:0] left_key;
         logic [SCORE_W-1:0]   left_aged;
         if (i == 0) begin : g_head
            assign left_key  = key_ff;
            assign left_aged = FRESH_SCORE;
         end else begin : g_body
            assign left_key  = cell_key[i-1];
            assign left_aged = cell_aged[i-1];
         end
         rbs_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_W     (CNT_W),
            .INDEX     (i)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .count      (count_ff),
            .probe_key  (probe_key),
            .shift      (shift[i]),
            .left_key   (left_key),
            .left_aged  (left_aged),
            .cell_key   (cell_key[i]),
            .cell_score (cell_score[i]),
            .cell_aged  (cell_aged[i]),
            .hit        (hit_vec[i]),
            .tail       (tail_vec[i])
         );
      end else begin : g_pad
         assign cell_key[i]   = '0;
         assign cell_score[i] = '0;
         assign cell_aged[i]  = '0;
         assign hit_vec[i]    = 1'b0;
         assign tail_vec[i]   = 1'b0;
      end
   end

   for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
      rbs_group #(
         .KEY_WIDTH (KEY_WIDTH),
         .SIZE      (GROUP_SIZE)
      ) u_group (
         .clock        (clock),
         .hit          (hit_vec[g*GROUP_SIZE +: GROUP_SIZE]),
         .tail         (tail_vec[g*GROUP_SIZE +: GROUP_SIZE]),
         .score        (cell_score[g*GROUP_SIZE +: GROUP_SIZE]),
         .key          (cell_key[g*GROUP_SIZE +: GROUP_SIZE]),
         .grp_hit_ff   (grp_hit[g]),
         .grp_score_ff (grp_score[g]),
         .grp_key_ff   (grp_key[g])
      );
   end

   // final reduction and shift region: cells up to the dropped one move back
   always_comb begin
      hit_any     = |grp_hit;
      score_or    = '0;
      tail_key_or = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         score_or    = score_or | grp_score[g];
         tail_key_or = tail_key_or | grp_key[g];
      end
      full  = SIZE_W'(count_ff) == stack_size_ff;
      evict = (cmd_ff == CMD_TOUCH) && !hit_any && full;
      d_pos = full ? count_ff - 1'b1 : count_ff;
      for (int i = 0; i < PAD; i++) begin
         is_d[i] = (i < MAX_DEPTH) && (d_pos == CNT_W'(i));
      end
      drop = hit_vec | ({PAD{!hit_any}} & is_d);
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_drop[g] = |drop[g*GROUP_SIZE +: GROUP_SIZE];
      end
      for (int g = 0; g < NUM_GROUPS; g++) begin
         later_drop[g] = 1'b0;
         for (int h = 0; h < NUM_GROUPS; h++) begin
            if (h > g) begin
               later_drop[g] = later_drop[g] | group_drop[h];
            end
         end
      end
      for (int i = 0; i < PAD; i++) begin
         shift[i] = later_drop[i / GROUP_SIZE];
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if ((i / GROUP_SIZE) * GROUP_SIZE + j >= i) begin
               shift[i] = shift[i] | drop[(i / GROUP_SIZE) * GROUP_SIZE + j];
            end
         end
      end
   end

   // count and stack size
   always_comb begin
      size_clamp = csr_wr_data;
      if (csr_wr_data == '0) begin
         size_clamp = SIZE_W'(1);
      end else if (csr_wr_data > SIZE_CAP) begin
         size_clamp = SIZE_CAP;
      end
      stack_size_in = stack_size_ff;
      count_in      = count_ff;
      priority if (csr_wr_en) begin
         stack_size_in = size_clamp;
         if (SIZE_W'(count_ff) > size_clamp) begin
            count_in = CNT_W'(size_clamp);
         end
      end else if (ctl.update && !hit_any && !full) begin
         count_in = count_ff + 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_score_in    = rsp_score_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_key_in   = rsp_ev_key_ff;
      if (fin_go) begin
         rsp_valid_in    = 1'b1;
         rsp_score_in    = score_or;
         rsp_ev_valid_in = evict;
         rsp_ev_key_in   = evict ? KEY_PORT_W'(tail_key_or) : '0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      key_ff          <= key_in;
      rsp_score_ff    <= rsp_score_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_key_ff   <= rsp_ev_key_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         stack_size_ff <= RESET_SIZE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         stack_size_ff <= stack_size_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.score         = rsp_score_ff;
   assign rsp.evicted_valid = rsp_ev_valid_ff;
   assign rsp.evicted_key   = rsp_ev_key_ff;

`ifndef SYNTHESIS
   a_count_le_size: assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(count_ff) <= stack_size_ff)
      else $error("entry count above stack size");

   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("key present in more than one cell");

   a_evict_no_score: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.evicted_valid) |-> (rsp.score == '0))
      else $error("eviction reported for a key that was present");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (ctl.update && !hit_any && !full) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("new key did not grow the stack");
`endif

endmodule

FILE: test/rbs_checker.sv
// Checker for the recency burst stack: watches both channels and the size register.
module rbs_checker import rbs_pkg::*; #(
   parameter int MAX_DEPTH = DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   rbs_req_if                req,
   rbs_rsp_if                rsp,
   output int                fail_count,
   output int                outstanding,
   output int                hit_count,
   output int                evict_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [SCORE_W-1:0]    score;
      logic                  evicted_valid;
      logic [KEY_PORT_W-1:0] evicted_key;
   } rsp_fields_type;

   logic [KEY_PORT_W-1:0] stack_key   [MAX_DEPTH];
   logic [SCORE_W-1:0]    stack_score [MAX_DEPTH];
   int unsigned           stack_count = 0;
   int unsigned           stack_limit = MAX_DEPTH;
   rsp_fields_type        awaited_rsp [$];
   int                    mismatches = 0;
   int                    waiting = 0;
   int                    hits = 0;
   int                    evictions = 0;

   assign fail_count  = mismatches;
   assign outstanding = waiting;
   assign hit_count   = hits;
   assign evict_count = evictions;

   function automatic void drop_oldest(int unsigned n);
      if (n > stack_count) n = stack_count;
      for (int unsigned i = 0; i + n < stack_count; i++) begin
         stack_key[i]   = stack_key[i + n];
         stack_score[i] = stack_score[i + n];
      end
      stack_count -= n;
   endfunction

   function automatic void set_limit(logic [SIZE_W-1:0] value);
      int unsigned s;
      s = (value == '0) ? 1 : int'(value);
      if (s > MAX_DEPTH) s = MAX_DEPTH;
      stack_limit = s;
      if (stack_count > stack_limit) drop_oldest(stack_count - stack_limit);
   endfunction

   // Score before the request; a touch then ages the rest and pushes the key.
   function automatic rsp_fields_type recency_update(rbs_cmd_type cmd,
                                                     logic [KEY_PORT_W-1:0] key);
      rsp_fields_type r;
      int unsigned    w;
      r = '0;
      for (int unsigned i = 0; i < stack_count; i++) begin
         if (stack_key[i] == key) begin
            r.score = stack_score[i];
            break;
         end
      end
      if (cmd == CMD_TOUCH) begin
         w = 0;
         for (int unsigned i = 0; i < stack_count; i++) begin
            if (stack_key[i] != key) begin
               stack_key[w]   = stack_key[i];
               stack_score[w] = (stack_score[i] != '0) ? stack_score[i] - 8'd1 : 8'd0;
               w++;
            end
         end
         stack_count = w;
         if (stack_count >= stack_limit && stack_count > 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_key   = stack_key[0];
            drop_oldest(stack_count - stack_limit + 1);
         end
         if (stack_count < MAX_DEPTH) begin
            stack_key[stack_count]   = key;
            stack_score[stack_count] = FRESH_SCORE;
            stack_count++;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_fields_type seen;
      rsp_fields_type want;
      if (reset) begin
         stack_count = 0;
         stack_limit = (SIZE_RESET > MAX_DEPTH) ? MAX_DEPTH : SIZE_RESET;
         awaited_rsp.delete();
      end else begin
         if (csr_wr_en) set_limit(csr_wr_data);
         if (rsp.valid && rsp.ready) begin
            seen = '{rsp.score, rsp.evicted_valid, rsp.evicted_key};
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unrequested response: score %0d evicted_valid %0b evicted_key %h",
                           $realtime, seen.score, seen.evicted_valid, seen.evicted_key);
            end else begin
               want = awaited_rsp.pop_front();
               if (want.score != '0) hits++;
               if (want.evicted_valid) evictions++;
               if (seen.score !== want.score || seen.evicted_valid !== want.evicted_valid ||
                   seen.evicted_key !== want.evicted_key) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   score         exp %0d got %0d", want.score, seen.score);
                     $display("   evicted_valid exp %0b got %0b", want.evicted_valid,
                              seen.evicted_valid);
                     $display("   evicted_key   exp %h got %h", want.evicted_key,
                              seen.evicted_key);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            awaited_rsp = {awaited_rsp, recency_update(rbs_cmd_type'(req.cmd), req.key)};
      end
      waiting = awaited_rsp.size();
   end

endmodule

FILE: test/tb_recency_burst_stack_unit.sv
// Testbench top for the recency burst stack: clock, reset, request stimulus and verdict.
module tb_recency_burst_stack_unit import rbs_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 20;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 12;
   localparam int IDLE_GAP_MAX   = 14;
   localparam int LONG_HOLD      = 90;
   localparam int TIMEOUT_CYCLES = 300000;
   localparam int FULL_DECAY     = 255;
   localparam int RECENT_N       = 16;
   localparam int POOL_MAX       = 150;

   localparam int N_PHASES       = 7;
   localparam int PRESSURE_PHASE = 2;
   localparam int PH_SIZE      [N_PHASES] = '{255,   1,   7, 128,   2,  16,  64};
   localparam int PH_ITEMS     [N_PHASES] = '{330,  60, 100, 110,  60, 130, 134};
   localparam int PH_POOL      [N_PHASES] = '{  0,   3,  10, 150,   4,  24,  90};
   localparam int PH_TOUCH_PCT [N_PHASES] = '{ 95,  60,  65,  70,  55,  65,  65};
   localparam int PH_GAP_PCT   [N_PHASES] = '{ 25,  30,   0,  20,  35,  15,   0};

   localparam logic [KEY_PORT_W-1:0] SAT_OLD = 32'h1234_5678;
   localparam logic [KEY_PORT_W-1:0] SAT_HOT = 32'hEDCB_A987;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;

   int fail_count;
   int outstanding;
   int hit_count;
   int evict_count;

   int   phase_no = -1;
   logic long_hold_done = 1'b0;
   logic sink_stalls = 1'b1;
   int   src_gap_pct = 0;
   int   touches = 0;
   int   lookups = 0;

   logic [KEY_PORT_W-1:0] recent [RECENT_N];
   int                    recent_at = 0;
   logic [KEY_PORT_W-1:0] pool   [POOL_MAX];

   rbs_req_if req_ch ();
   rbs_rsp_if rsp_ch ();

   recency_burst_stack_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   rbs_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .hit_count   (hit_count),
      .evict_count (evict_count)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   task automatic offer(input rbs_cmd_type cmd, input logic [KEY_PORT_W-1:0] key);
      if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, IDLE_GAP_MAX)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd   <= cmd;
      req_ch.key   <= key;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == CMD_TOUCH) begin
         touches++;
         recent[recent_at] = key;
         recent_at = (recent_at + 1) % RECENT_N;
      end else begin
         lookups++;
      end
   endtask

   // Size writes only once every response is back and the chain has settled.
   task automatic set_size(input logic [SIZE_W-1:0] value);
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : receiver
      int unsigned span;
      logic        level;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_no == PRESSURE_PHASE && !long_hold_done) begin
            level          = 1'b0;
            span           = LONG_HOLD;
            long_hold_done = 1'b1;
         end else if (sink_stalls && $urandom_range(0, 2) == 0) begin
            level = 1'b0;
            span  = $urandom_range(1, IDLE_GAP_MAX);
         end else begin
            level = 1'b1;
            span  = $urandom_range(1, 24);
         end
         rsp_ch.ready <= level;
         repeat (span - 1) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [KEY_PORT_W-1:0] key;
      rbs_cmd_type           cmd;
      req_ch.valid <= 1'b0;
      req_ch.cmd   <= CMD_TOUCH;
      req_ch.key   <= '0;
      csr_wr_en    <= 1'b0;
      csr_wr_data  <= '0;
      foreach (recent[i]) recent[i] = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: empty stack, key extremes, touch of a present key
      src_gap_pct = 20;
      offer(CMD_LOOKUP, 32'h0000_0000);
      offer(CMD_TOUCH,  32'h0000_0000);
      offer(CMD_TOUCH,  32'hFFFF_FFFF);
      offer(CMD_LOOKUP, 32'h0000_0000);
      offer(CMD_LOOKUP, 32'hFFFF_FFFF);
      offer(CMD_TOUCH,  32'h0000_0000);
      offer(CMD_LOOKUP, 32'h5A5A_5A5A);

      // size zero reads as one: shrink drops the oldest, every new touch evicts
      set_size(8'd0);
      offer(CMD_TOUCH,  32'hA5A5_A5A5);
      offer(CMD_TOUCH,  32'hA5A5_A5A5);
      offer(CMD_LOOKUP, 32'h0000_0000);

      set_size(8'd3);
      offer(CMD_TOUCH,  32'h0000_0001);
      offer(CMD_TOUCH,  32'h0000_0002);
      offer(CMD_TOUCH,  32'h0000_0003);
      offer(CMD_TOUCH,  32'h8000_0000);
      offer(CMD_LOOKUP, 32'h0000_0002);
      offer(CMD_TOUCH,  32'h0000_0002);
      offer(CMD_LOOKUP, 32'h7FFF_FFFF);

      // score saturation: age one key past zero while it stays resident
      set_size(8'd2);
      offer(CMD_TOUCH, SAT_OLD);
      repeat (FULL_DECAY + 1) offer(CMD_TOUCH, SAT_HOT);
      offer(CMD_LOOKUP, SAT_OLD);
      offer(CMD_TOUCH, SAT_OLD);

      for (int p = 0; p < N_PHASES; p++) begin
         set_size(SIZE_W'(PH_SIZE[p]));
         phase_no    = p;
         src_gap_pct = PH_GAP_PCT[p];
         sink_stalls = (p != N_PHASES - 1);
         for (int i = 0; i < PH_POOL[p]; i++) pool[i] = $urandom();
         repeat (PH_ITEMS[p]) begin
            cmd = ($urandom_range(0, 99) < PH_TOUCH_PCT[p]) ? CMD_TOUCH : CMD_LOOKUP;
            if (cmd == CMD_LOOKUP && $urandom_range(0, 1) == 0)
               key = recent[$urandom_range(0, RECENT_N - 1)];
            else if (PH_POOL[p] == 0 || $urandom_range(0, 9) == 0)
               key = $urandom();
            else
               key = pool[$urandom_range(0, PH_POOL[p] - 1)];
            offer(cmd, key);
         end
      end

      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d touches and %0d lookups over %0d stack sizes,",
               touches, lookups, N_PHASES + 3);
      $display("including %0d nonzero scores and %0d evictions.", hit_count, evict_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Timeout with %0d responses outstanding", outstanding);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: recency_burst_stack_unit.f
hw/rtl/rbs_pkg.sv
hw/rtl/rbs_if.sv
hw/rtl/rbs_cell.sv
hw/rtl/rbs_group.sv
hw/rtl/recency_burst_stack_unit.sv
test/rbs_checker.sv
test/tb_recency_burst_stack_unit.sv
